// ===== sv/mexp_pkg.sv =====
// Package: shared constants, types and controller states for the modular exponentiation core.
`default_nettype none
package mexp_pkg;
  localparam int unsigned Width    = 64;
  localparam int unsigned CntWidth = $clog2(Width + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_START,
    ST_MUL_RUN,
    ST_SQR_START,
    ST_SQR_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic sqr_start;
    logic step;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
    logic mm_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/mexp_modmul.sv =====
// Iterative modular multiplier: shift-and-add, one multiplier bit per cycle.
`default_nettype none
module mexp_modmul
  import mexp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] x_i,
  input  wire logic [Width-1:0] y_i,
  input  wire logic [Width-1:0] m_i,
  output logic                  done_o,
  output logic      [Width-1:0] r_o
);
  logic [Width-1:0]    r_q, r_d, y_q, x_q;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [Width:0]      dbl, dbl_red, sum;
  logic [Width-1:0]    r1;

  // Per step: r = 2r mod m, then add x mod m when the multiplier bit is set.
  // Needs x < m; y may be unreduced. done holds until the next start.
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    r1      = dbl_red[Width-1:0];
    sum     = {1'b0, r1} + {1'b0, x_q};
    if (y_q[Width-1]) begin
      r_d = (sum >= {1'b0, m_i}) ? Width'(sum - {1'b0, m_i}) : sum[Width-1:0];
    end else begin
      r_d = r1;
    end
    cnt_d  = cnt_q - CntWidth'(1);
    busy_d = busy_q && (cnt_q != CntWidth'(1));
    done_d = busy_q ? (cnt_q == CntWidth'(1)) : done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntWidth'(Width);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (busy_q) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      x_q <= x_i;
      y_q <= y_i;
    end else if (busy_q) begin
      r_q <= r_d;
      y_q <= {y_q[Width-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;
endmodule
`default_nettype wire

// ===== sv/mexp_dp.sv =====
// Datapath: operand registers, exponent shifter, input reduction and shared modular multiplier.
`default_nettype none
module mexp_dp
  import mexp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [Width-1:0] base_i,
  input  wire logic [Width-1:0] exp_i,
  input  wire logic [Width-1:0] mod_i,
  output stat_t                 stat_o,
  output logic      [Width-1:0] acc_o
);
  logic [Width-1:0] acc_q, sq_q, exp_q, mod_q, mm_r, mm_x, mm_y;
  logic             mm_start, mm_done, sel_sqr_q;

  // The multiplier needs x < m, so the base is reduced at load by a
  // separate bit-serial remainder pass. A dummy 0*0 multiply is started
  // at load so that done is up when the reduction ends.
  assign mm_start = cmd_i.load | cmd_i.mul_start | cmd_i.sqr_start;
  always_comb begin
    if (cmd_i.load) begin
      mm_x = '0;
      mm_y = '0;
    end else if (cmd_i.mul_start) begin
      mm_x = sq_q;
      mm_y = acc_q;
    end else begin
      mm_x = sq_q;
      mm_y = sq_q;
    end
  end

  mexp_modmul u_mm (
    .clk_i,
    .rst_ni,
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (mod_q),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  // Base mod m: shift base bits into red_q MSB first, one subtract per step.
  logic [Width-1:0] red_q;
  logic [CntWidth-1:0] rc_q;
  logic             red_busy_q;
  logic [Width:0]   red_dbl, red_nx;

  always_comb begin
    red_dbl = {red_q, sq_q[Width-1]};
    red_nx  = (red_dbl >= {1'b0, mod_q}) ? red_dbl - {1'b0, mod_q} : red_dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_busy_q <= 1'b0;
      rc_q       <= '0;
      sel_sqr_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        red_busy_q <= 1'b1;
        rc_q       <= CntWidth'(Width);
      end else if (red_busy_q) begin
        rc_q       <= rc_q - CntWidth'(1);
        red_busy_q <= (rc_q != CntWidth'(1));
      end
      if (cmd_i.mul_start) sel_sqr_q <= 1'b0;
      else if (cmd_i.sqr_start) sel_sqr_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= Width'(1);
      sq_q  <= base_i;
      exp_q <= exp_i;
      mod_q <= mod_i;
      red_q <= '0;
    end else if (red_busy_q) begin
      red_q <= red_nx[Width-1:0];
      sq_q  <= (rc_q == CntWidth'(1)) ? red_nx[Width-1:0] : {sq_q[Width-2:0], 1'b0};
    end else begin
      if (mm_done && cmd_i.run) begin
        if (sel_sqr_q) sq_q <= mm_r;
        else acc_q <= mm_r;
      end
      if (cmd_i.step) exp_q <= {1'b0, exp_q[Width-1:1]};
    end
  end

  assign stat_o.exp_zero = (exp_q == '0);
  assign stat_o.exp_lsb  = exp_q[0];
  assign stat_o.mod_zero = (mod_q == '0);
  assign stat_o.mm_done  = mm_done & ~red_busy_q;
  assign acc_o           = acc_q;
endmodule
`default_nettype wire

// ===== sv/mexp_ctrl.sv =====
// Controller: sequences load, multiply and square over the exponent bits and the output handshake.
`default_nettype none
module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_fire_i,
  input  wire logic  out_free_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       ready_o,
  output logic       done_o
);
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_fire_i) state_d = ST_LOAD;
      ST_LOAD: begin
        if (stat_i.mod_zero || stat_i.exp_zero) state_d = ST_DONE;
        else state_d = ST_MUL_START;
      end
      ST_MUL_START: begin
        if (stat_i.mm_done) begin
          if (stat_i.exp_lsb) state_d = ST_MUL_RUN;
          else state_d = ST_SQR_RUN;
        end
      end
      ST_MUL_RUN:   if (stat_i.mm_done) state_d = ST_SQR_START;
      ST_SQR_START: state_d = ST_SQR_RUN;
      ST_SQR_RUN: begin
        if (stat_i.mm_done) begin
          if (stat_i.exp_zero) state_d = ST_DONE;
          else state_d = ST_MUL_START;
        end
      end
      ST_DONE:      if (out_free_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // ST_MUL_START waits for the load-time base reduction (or previous square)
  // to settle, then launches either the multiply or the square.
  always_comb begin
    cmd_o   = '0;
    ready_o = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ready_o    = 1'b1;
        cmd_o.load = in_fire_i;
      end
      ST_MUL_START: begin
        cmd_o.mul_start = stat_i.mm_done & stat_i.exp_lsb;
        cmd_o.sqr_start = stat_i.mm_done & ~stat_i.exp_lsb;
        cmd_o.step      = stat_i.mm_done & ~stat_i.exp_lsb;
      end
      ST_MUL_RUN:   cmd_o.run = 1'b1;
      ST_SQR_START: begin
        cmd_o.sqr_start = 1'b1;
        cmd_o.step      = 1'b1;
      end
      ST_SQR_RUN:   cmd_o.run = 1'b1;
      ST_DONE:      done_o = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== sv/modular_exponentiation_core.sv =====
// Top level: modular exponentiation core (right-to-left square and multiply).
// The base is first reduced mod m; then each exponent bit that is one takes
//   a multiply and a square, and each bit that is zero a square only, up to
//   the top set bit.
// Zero exponent or zero modulus skips the loop. One request at a time.
// Reset clears controller and output valid; the block is idle after reset.
`default_nettype none
module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,  // base_value[63:0], exponent[127:64], modulus[191:128]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // power_result[63:0]
  output logic              m_axis_tuser   // status
);
  cmd_t  cmd;
  stat_t stat;
  logic  in_fire, ready, done, out_free, ovalid_q;
  logic  [Width-1:0] acc, res_q;
  logic  err_q;

  assign s_axis_tready = ready;
  assign in_fire  = s_axis_tvalid & ready;
  assign out_free = ~ovalid_q | m_axis_tready;

  mexp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .ready_o    (ready),
    .done_o     (done)
  );

  mexp_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .base_i (s_axis_tdata[63:0]),
    .exp_i  (s_axis_tdata[127:64]),
    .mod_i  (s_axis_tdata[191:128]),
    .stat_o (stat),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done && out_free) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      res_q <= stat.mod_zero ? '0 : acc;
      err_q <= stat.mod_zero;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("error result nonzero");
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready) else $error("accepted while busy");
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !ready) else $error("done while idle");
endmodule
`default_nettype wire
